[rtl/sbas_pkg.sv]
// Shared types, constants and tables of the softmax bandit arm selector.
`timescale 1ns / 1ps

package sbas_pkg;

    localparam int MAX_ARMS_DEF = 16;

    localparam int NUM_ARMS_W = 5;
    localparam int ETA_W      = 16;
    localparam int C_W        = 16;
    localparam int ALPHA_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 5;

    localparam logic [NUM_ARMS_W-1:0] NUM_ARMS_RST = 5'd2;
    localparam logic [ETA_W-1:0]      ETA_RST      = 16'd1638;
    localparam logic [C_W-1:0]        C_PARAM_RST  = 16'd819;
    localparam logic [ALPHA_W-1:0]    ALPHA_RST    = 15'd11469;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ARMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ETA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C_PARAM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd3;

    // Last step index of each iterative unit.
    localparam logic [STEP_W-1:0] LOG_LAST  = 5'd15;
    localparam logic [STEP_W-1:0] EXP_LAST  = 5'd15;
    localparam logic [STEP_W-1:0] SQRT_LAST = 5'd23;
    localparam logic [STEP_W-1:0] DIV_LAST  = 5'd15;

    // log2(e) in Q.16.
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef struct packed {
        logic        action;
        logic [3:0]  arm;
        logic [15:0] reward;
        logic [15:0] random_draw;
    } sbas_item_t;

    typedef struct packed {
        logic [3:0] chosen_arm;
        logic       explored;
        logic       epoch_advanced;
    } sbas_result_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOG_INIT,
        OP_LOG_STEP,
        OP_POW_MUL,
        OP_EXP_STEP,
        OP_ELEN_MUL,
        OP_ELEN,
        OP_THR,
        OP_DECIDE,
        OP_RR,
        OP_SQRT_STEP,
        OP_ES,
        OP_W_MUL,
        OP_MAX_CMP,
        OP_Q,
        OP_EXP_INIT,
        OP_EXP_STORE,
        OP_TGT,
        OP_PICK,
        OP_REW_INC,
        OP_REW_MUL,
        OP_DIV_STEP,
        OP_REW_END
    } sbas_op_t;

    typedef struct packed {
        sbas_op_t          op;
        logic [STEP_W-1:0] step;
    } sbas_cmd_t;

    typedef struct packed {
        logic action;
        logic explore_hit;
        logic in_use;
        logic rr_done;
        logic idx_last;
        logic pick_done;
    } sbas_status_t;

    // 2^(2^-(k+1)) in Q.16.
    function automatic logic [16:0] exp2_tab(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:    v = 17'd92682;
            4'd1:    v = 17'd77936;
            4'd2:    v = 17'd71468;
            4'd3:    v = 17'd68438;
            4'd4:    v = 17'd66971;
            4'd5:    v = 17'd66250;
            4'd6:    v = 17'd65892;
            4'd7:    v = 17'd65714;
            4'd8:    v = 17'd65625;
            4'd9:    v = 17'd65580;
            4'd10:   v = 17'd65558;
            4'd11:   v = 17'd65547;
            4'd12:   v = 17'd65542;
            4'd13:   v = 17'd65539;
            4'd14:   v = 17'd65537;
            default: v = 17'd65537;
        endcase
        return v;
    endfunction

endpackage

[rtl/softmax_bandit_arm_selector_top.sv]
// Top level of the softmax bandit arm selector.
`timescale 1ns / 1ps

//  channel   signals                              transfer when
//  item      start, busy, item                    start high and busy low
//  result    result_valid, result                 result_valid high, one cycle
//  config    cfg_valid, cfg_ready, cfg_index,     cfg_valid and cfg_ready high
//            cfg_data
//
// One item at a time. Every item first computes the exploration length with the
// 16-step log2 and 16-step exp2 units. Exploration, a reward (16-step divider,
// skipped for an arm not in use) or a softmax pick (24-step square root and one
// 16-step exp2 per arm) then follows.
// The result strobe is raised in the cycle after the last processing state and cannot be held off.
// Reset is asynchronous; statistics come out of reset cleared.

module softmax_bandit_arm_selector_top #(
    parameter int MAX_ARMS = sbas_pkg::MAX_ARMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  sbas_pkg::sbas_item_t            item,
    output logic                            result_valid,
    output sbas_pkg::sbas_result_t          result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbas_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sbas_pkg::*;

    sbas_cmd_t    cmd;
    sbas_status_t status;

    assign cfg_ready = 1'b1;

    sbas_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    sbas_dp #(
        .MAX_ARMS (MAX_ARMS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .result    (result)
    );

endmodule

[rtl/sbas_ctrl.sv]
// Sequencing state machine of the arm selector.
`timescale 1ns / 1ps

module sbas_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  sbas_pkg::sbas_status_t status,
    output sbas_pkg::sbas_cmd_t    cmd,
    output logic                   busy,
    output logic                   result_valid
);
    import sbas_pkg::*;

    typedef enum logic [25:0] {
        ST_IDLE      = 26'h0000001,
        ST_LOG_INIT  = 26'h0000002,
        ST_LOG       = 26'h0000004,
        ST_POW_MUL   = 26'h0000008,
        ST_POW_EXP   = 26'h0000010,
        ST_ELEN_MUL  = 26'h0000020,
        ST_ELEN      = 26'h0000040,
        ST_THR       = 26'h0000080,
        ST_DECIDE    = 26'h0000100,
        ST_RR        = 26'h0000200,
        ST_SQRT      = 26'h0000400,
        ST_ES        = 26'h0000800,
        ST_MAX_MUL   = 26'h0001000,
        ST_MAX_CMP   = 26'h0002000,
        ST_EXP_MUL   = 26'h0004000,
        ST_EXP_Q     = 26'h0008000,
        ST_EXP_INIT  = 26'h0010000,
        ST_EXP_RUN   = 26'h0020000,
        ST_EXP_STORE = 26'h0040000,
        ST_TGT       = 26'h0080000,
        ST_PICK      = 26'h0100000,
        ST_REW_INC   = 26'h0200000,
        ST_REW_MUL   = 26'h0400000,
        ST_DIV       = 26'h0800000,
        ST_REW_END   = 26'h1000000,
        ST_OUT       = 26'h2000000
    } sbas_state_t;

    sbas_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_LOG_INIT;
                end
            end
            ST_LOG_INIT:
            begin
                cmd.op     = OP_LOG_INIT;
                step_next  = '0;
                state_next = ST_LOG;
            end
            ST_LOG:
            begin
                cmd.op = OP_LOG_STEP;
                if (step_reg == LOG_LAST)
                    state_next = ST_POW_MUL;
                else
                    step_next = step_reg + 5'd1;
            end
            ST_POW_MUL:
            begin
                cmd.op     = OP_POW_MUL;
                step_next  = '0;
                state_next = ST_POW_EXP;
            end
            ST_POW_EXP:
            begin
                cmd.op = OP_EXP_STEP;
                if (step_reg == EXP_LAST)
                    state_next = ST_ELEN_MUL;
                else
                    step_next = step_reg + 5'd1;
            end
            ST_ELEN_MUL:
            begin
                cmd.op     = OP_ELEN_MUL;
                state_next = ST_ELEN;
            end
            ST_ELEN:
            begin
                cmd.op     = OP_ELEN;
                state_next = ST_THR;
            end
            ST_THR:
            begin
                cmd.op     = OP_THR;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.op    = OP_DECIDE;
                step_next = '0;
                if (status.action)
                    state_next = status.in_use ? ST_REW_INC : ST_REW_END;
                else
                    state_next = status.explore_hit ? ST_RR : ST_SQRT;
            end
            ST_RR:
            begin
                cmd.op = OP_RR;
                if (status.rr_done)
                    state_next = ST_OUT;
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                if (step_reg == SQRT_LAST)
                    state_next = ST_ES;
                else
                    step_next = step_reg + 5'd1;
            end
            ST_ES:
            begin
                cmd.op     = OP_ES;
                state_next = ST_MAX_MUL;
            end
            ST_MAX_MUL:
            begin
                cmd.op     = OP_W_MUL;
                state_next = ST_MAX_CMP;
            end
            ST_MAX_CMP:
            begin
                cmd.op     = OP_MAX_CMP;
                state_next = status.idx_last ? ST_EXP_MUL : ST_MAX_MUL;
            end
            ST_EXP_MUL:
            begin
                cmd.op     = OP_W_MUL;
                state_next = ST_EXP_Q;
            end
            ST_EXP_Q:
            begin
                cmd.op     = OP_Q;
                state_next = ST_EXP_INIT;
            end
            ST_EXP_INIT:
            begin
                cmd.op     = OP_EXP_INIT;
                step_next  = '0;
                state_next = ST_EXP_RUN;
            end
            ST_EXP_RUN:
            begin
                cmd.op = OP_EXP_STEP;
                if (step_reg == EXP_LAST)
                    state_next = ST_EXP_STORE;
                else
                    step_next = step_reg + 5'd1;
            end
            ST_EXP_STORE:
            begin
                cmd.op     = OP_EXP_STORE;
                state_next = status.idx_last ? ST_TGT : ST_EXP_MUL;
            end
            ST_TGT:
            begin
                cmd.op     = OP_TGT;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.op = OP_PICK;
                if (status.pick_done)
                    state_next = ST_OUT;
            end
            ST_REW_INC:
            begin
                cmd.op     = OP_REW_INC;
                state_next = ST_REW_MUL;
            end
            ST_REW_MUL:
            begin
                cmd.op     = OP_REW_MUL;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (step_reg == DIV_LAST)
                    state_next = ST_REW_END;
                else
                    step_next = step_reg + 5'd1;
            end
            ST_REW_END:
            begin
                cmd.op     = OP_REW_END;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);

endmodule

[rtl/sbas_dp.sv]
// Datapath of the arm selector: configuration, arm statistics and arithmetic units.
`timescale 1ns / 1ps

module sbas_dp #(
    parameter int MAX_ARMS = sbas_pkg::MAX_ARMS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbas_pkg::sbas_item_t                item,
    input  sbas_pkg::sbas_cmd_t                 cmd,
    input  logic                                cfg_we,
    input  logic [sbas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sbas_pkg::CFG_DATA_W-1:0]     cfg_data,
    output sbas_pkg::sbas_status_t              status,
    output sbas_pkg::sbas_result_t              result
);
    import sbas_pkg::*;

    localparam int AW  = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
    localparam int IW  = (AW > NUM_ARMS_W) ? AW : NUM_ARMS_W;
    localparam int SW  = 24 + AW;
    localparam int TW  = SW + 16;
    localparam int NEW = IW + 20;

    // Configuration.
    logic [NUM_ARMS_W-1:0] num_arms_reg;
    logic [ETA_W-1:0]      eta_reg;
    logic [C_W-1:0]        c_reg;
    logic [ALPHA_W-1:0]    alpha_reg;

    // Arm statistics and selector state.
    logic [31:0] pull_reg [MAX_ARMS];
    logic [15:0] mean_reg [MAX_ARMS];
    logic [31:0] step_time_reg;
    logic [5:0]  epoch_reg;
    logic [31:0] esteps_reg;
    logic [IW-1:0] last_reg;
    logic        last_valid_reg;
    logic        explored_reg;
    logic        adv_reg;

    // Latched item and working registers.
    logic        act_reg;
    logic [3:0]  arm_reg;
    logic [15:0] reward_reg;
    logic [15:0] draw_reg;
    logic [23:0] ew_reg [MAX_ARMS];
    logic [30:0] ly_reg;
    logic [15:0] lbits_reg;
    logic [2:0]  lip_reg;
    logic [16:0] xy_reg;
    logic [15:0] xf_reg;
    logic [3:0]  pip_reg;
    logic [32:0] prod_reg;
    logic [19:0] e_reg;
    logic [NEW-1:0] ne_reg;
    logic [IW-1:0] rr_reg;
    logic [47:0] sqv_reg;
    logic [47:0] sqr_reg;
    logic [39:0] es_reg;
    logic [35:0] w_reg;
    logic [35:0] mx_reg;
    logic [36:0] q_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] cum_reg;
    logic [TW-1:0] tgt_reg;
    logic [IW-1:0] idx_reg;
    logic [31:0] t_reg;
    logic [49:0] rem_reg;
    logic [15:0] quot_reg;

    // Combinational helpers.
    logic [IW-1:0]  n_arms;
    logic [IW-1:0]  arm_ext;
    logic [AW-1:0]  rd_idx;
    logic [15:0]    mean_rd;
    logic [2:0]     ep_ip;
    logic [30:0]    ep_ext;
    logic [61:0]    lsq;
    logic [31:0]    lsq_hi;
    logic [33:0]    pow_p;
    logic [33:0]    xprod;
    logic [32:0]    cprod;
    logic [47:0]    elen_sh;
    logic [NEW-1:0] ne_prod;
    logic [47:0]    sq_bit;
    logic [48:0]    sq_trial;
    logic [39:0]    es_prod;
    logic [55:0]    w_prod;
    logic [52:0]    q_prod;
    logic [23:0]    exp_v;
    logic [23:0]    ew_new;
    logic [TW-1:0]  tgt_prod;
    logic [SW-1:0]  cum_nx;
    logic           pick_hit;
    logic [31:0]    pc_new;
    logic [47:0]    rem_prod;
    logic [3:0]     div_k;
    logic [49:0]    div_d;
    logic [31:0]    st_inc;
    logic [31:0]    es_inc;
    logic [45:0]    thr;
    logic           close_ep;

    always_comb
    begin
        if (num_arms_reg == '0)
            n_arms = IW'(1);
        else if (int'(num_arms_reg) > MAX_ARMS)
            n_arms = IW'(MAX_ARMS);
        else
            n_arms = IW'(num_arms_reg);
    end

    assign arm_ext = IW'(arm_reg);
    assign rd_idx  = act_reg ? arm_ext[AW-1:0] : idx_reg[AW-1:0];
    assign mean_rd = mean_reg[rd_idx];

    always_comb
    begin
        ep_ip = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (epoch_reg[i])
                ep_ip = 3'(i);
        end
    end

    assign ep_ext  = {25'd0, epoch_reg};
    assign lsq     = ly_reg * ly_reg;
    assign lsq_hi  = lsq[61:30];
    assign pow_p   = alpha_reg * {lip_reg, lbits_reg};
    assign xprod   = xy_reg * exp2_tab(cmd.step[3:0]);
    assign cprod   = c_reg * xy_reg;
    assign elen_sh = {15'd0, prod_reg} << pip_reg;
    assign ne_prod = n_arms * e_reg;

    assign sq_bit   = 48'd1 << (6'd46 - {cmd.step, 1'b0});
    assign sq_trial = {1'b0, sqr_reg} + {1'b0, sq_bit};

    assign es_prod = eta_reg * sqr_reg[23:0];
    assign w_prod  = es_reg * mean_rd;
    assign q_prod  = (mx_reg - w_reg) * LOG2E_Q16;

    // A zero fraction gives exactly one; otherwise the table product scaled to Q1.23.
    assign exp_v  = (q_reg[15:0] == '0) ? 24'h800000 : 24'({xy_reg, 6'd0});
    assign ew_new = (q_reg[36:16] >= 21'd24) ? '0 : (exp_v >> q_reg[20:16]);

    assign tgt_prod = draw_reg * sum_reg;
    assign cum_nx   = cum_reg + SW'(ew_reg[idx_reg[AW-1:0]]);
    assign pick_hit = ({cum_reg, 16'd0} <= tgt_reg) && (tgt_reg <= {cum_nx, 16'd0});

    assign pc_new   = (pull_reg[rd_idx] == '1) ? pull_reg[rd_idx] : pull_reg[rd_idx] + 32'd1;
    assign rem_prod = (t_reg - 32'd1) * mean_rd;
    assign div_k    = 4'd15 - cmd.step[3:0];
    assign div_d    = {18'd0, t_reg} << div_k;

    assign st_inc = (step_time_reg == '1) ? step_time_reg : step_time_reg + 32'd1;
    assign es_inc = (esteps_reg == '1) ? esteps_reg : esteps_reg + 32'd1;
    assign thr    = 46'(ne_reg) + (46'(n_arms) << epoch_reg);
    // From epoch 40 on the threshold is beyond any step count.
    assign close_ep = (epoch_reg < 6'd40) && (46'(es_inc) >= thr);

    assign status.action      = act_reg;
    assign status.explore_hit = (64'(esteps_reg) < 64'(ne_reg));
    assign status.in_use      = (arm_ext < n_arms);
    assign status.rr_done     = (rr_reg < n_arms);
    assign status.idx_last    = (idx_reg == n_arms - IW'(1));
    assign status.pick_done   = pick_hit || (idx_reg == n_arms - IW'(1));

    assign result.chosen_arm     = last_reg[3:0];
    assign result.explored       = explored_reg;
    assign result.epoch_advanced = adv_reg;

    // Configuration, arm statistics and selector state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_arms_reg   <= NUM_ARMS_RST;
            eta_reg        <= ETA_RST;
            c_reg          <= C_PARAM_RST;
            alpha_reg      <= ALPHA_RST;
            for (int i = 0; i < MAX_ARMS; i++)
            begin
                pull_reg[i] <= '0;
                mean_reg[i] <= '0;
            end
            step_time_reg  <= 32'd1;
            epoch_reg      <= 6'd1;
            esteps_reg     <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            explored_reg   <= 1'b0;
            adv_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NUM_ARMS: num_arms_reg <= cfg_data[NUM_ARMS_W-1:0];
                    REG_ETA:      eta_reg      <= cfg_data[ETA_W-1:0];
                    REG_C_PARAM:  c_reg        <= cfg_data[C_W-1:0];
                    REG_ALPHA:    alpha_reg    <= cfg_data[ALPHA_W-1:0];
                    default:      ;
                endcase
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    explored_reg <= 1'b0;
                    adv_reg      <= 1'b0;
                end
                OP_RR:
                begin
                    if (rr_reg < n_arms)
                    begin
                        last_reg       <= rr_reg;
                        last_valid_reg <= 1'b1;
                        explored_reg   <= 1'b1;
                    end
                end
                OP_PICK:
                begin
                    if (pick_hit)
                    begin
                        last_reg       <= idx_reg;
                        last_valid_reg <= 1'b1;
                    end
                    else if (idx_reg == n_arms - IW'(1))
                    begin
                        last_valid_reg <= 1'b1;
                    end
                end
                OP_REW_INC:
                begin
                    pull_reg[rd_idx] <= pc_new;
                end
                OP_REW_END:
                begin
                    if (arm_ext < n_arms)
                        mean_reg[rd_idx] <= quot_reg;
                    step_time_reg <= st_inc;
                    if (close_ep)
                    begin
                        esteps_reg <= '0;
                        if (epoch_reg != 6'd63)
                            epoch_reg <= epoch_reg + 6'd1;
                        adv_reg <= 1'b1;
                    end
                    else
                    begin
                        esteps_reg <= es_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                act_reg    <= item.action;
                arm_reg    <= item.arm;
                reward_reg <= item.reward;
                draw_reg   <= item.random_draw;
            end
            OP_LOG_INIT:
            begin
                ly_reg    <= ep_ext << (5'd30 - 5'(ep_ip));
                lbits_reg <= '0;
                lip_reg   <= ep_ip;
            end
            OP_LOG_STEP:
            begin
                lbits_reg <= {lbits_reg[14:0], lsq_hi[31]};
                ly_reg    <= lsq_hi[31] ? lsq_hi[31:1] : lsq_hi[30:0];
            end
            OP_POW_MUL:
            begin
                pip_reg <= pow_p[33:30];
                xf_reg  <= pow_p[29:14];
                xy_reg  <= 17'h10000;
            end
            OP_EXP_STEP:
            begin
                if (xf_reg[4'd15 - cmd.step[3:0]])
                    xy_reg <= xprod[32:16];
            end
            OP_ELEN_MUL:
            begin
                prod_reg <= cprod;
            end
            OP_ELEN:
            begin
                e_reg <= elen_sh[47:28];
            end
            OP_THR:
            begin
                ne_reg <= ne_prod;
            end
            OP_DECIDE:
            begin
                rr_reg  <= last_valid_reg ? last_reg + IW'(1) : '0;
                sqv_reg <= {step_time_reg - 32'd1, 16'd0};
                sqr_reg <= '0;
            end
            OP_RR:
            begin
                if (rr_reg >= n_arms)
                    rr_reg <= rr_reg - n_arms;
            end
            OP_SQRT_STEP:
            begin
                if ({1'b0, sqv_reg} >= sq_trial)
                begin
                    sqv_reg <= sqv_reg - sq_trial[47:0];
                    sqr_reg <= (sqr_reg >> 1) + sq_bit;
                end
                else
                begin
                    sqr_reg <= sqr_reg >> 1;
                end
            end
            OP_ES:
            begin
                es_reg  <= es_prod;
                idx_reg <= '0;
                mx_reg  <= '0;
            end
            OP_W_MUL:
            begin
                w_reg <= w_prod[55:20];
            end
            OP_MAX_CMP:
            begin
                if (w_reg > mx_reg)
                    mx_reg <= w_reg;
                if (idx_reg == n_arms - IW'(1))
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            OP_Q:
            begin
                q_reg <= q_prod[52:16];
            end
            OP_EXP_INIT:
            begin
                xf_reg <= 16'd0 - q_reg[15:0];
                xy_reg <= 17'h10000;
            end
            OP_EXP_STORE:
            begin
                ew_reg[idx_reg[AW-1:0]] <= ew_new;
                sum_reg <= sum_reg + SW'(ew_new);
                if (idx_reg != n_arms - IW'(1))
                    idx_reg <= idx_reg + IW'(1);
            end
            OP_TGT:
            begin
                tgt_reg <= tgt_prod;
                idx_reg <= '0;
                cum_reg <= '0;
            end
            OP_PICK:
            begin
                cum_reg <= cum_nx;
                idx_reg <= idx_reg + IW'(1);
            end
            OP_REW_INC:
            begin
                t_reg <= pc_new;
            end
            OP_REW_MUL:
            begin
                rem_reg  <= 50'(rem_prod) + 50'(reward_reg) + 50'(t_reg >> 1);
                quot_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                if (rem_reg >= div_d)
                begin
                    rem_reg          <= rem_reg - div_d;
                    quot_reg[div_k]  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
